>>> hw/rtl/scpa_pkg.sv
`default_nettype none

package scpa_pkg;

  // Pool shape
  localparam int unsigned NUM_CLASSES   = 6;
  localparam int unsigned BASE_OBJECTS  = 1024;
  localparam int unsigned SMALLEST_SLOT = 512;

  // Field widths
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned CLS_W   = 3;
  localparam int unsigned IDX_W   = 11;
  localparam int unsigned CNT_W   = 12;
  localparam int unsigned BYTES_W = 15;
  localparam int unsigned STAT_W  = 3;

  // Free rings share one memory: class 0 first (double size), then the others
  localparam int unsigned RING_DEPTH = 2 * BASE_OBJECTS + (NUM_CLASSES - 1) * BASE_OBJECTS;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);

  // Front-to-back queue
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_ALLOC  = 3'd0,
    ST_FREED  = 3'd1,
    ST_TOOBIG = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_BAD    = 3'd4
  } status_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_READ = 1'b1
  } back_state_e;

  // Classified request as it waits in the queue
  typedef struct packed {
    op_e              op;
    logic             too_big;   // allocate larger than the biggest slot
    logic             bad;       // release handle out of range
    logic [CLS_W-1:0] cls;
    logic [IDX_W-1:0] idx;
  } req_t;

  function automatic logic [CNT_W-1:0] class_cap(input logic [CLS_W-1:0] c);
    return (c == '0) ? CNT_W'(2 * BASE_OBJECTS) : CNT_W'(BASE_OBJECTS);
  endfunction

  function automatic logic [BYTES_W-1:0] class_bytes(input logic [CLS_W-1:0] c);
    return BYTES_W'(SMALLEST_SLOT) << c;
  endfunction

  function automatic logic [RING_AW-1:0] class_base(input logic [CLS_W-1:0] c);
    return (c == '0) ? '0 : RING_AW'((32'(c) + 32'd1) * BASE_OBJECTS);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/size_class_pool_allocator.sv
`default_nettype none

// Size-class slot allocator with six power-of-two classes (512 .. 16384 bytes).
// Slave stream: one beat is one request. tuser is the op (0 allocate,
// 1 release); tdata carries size, release class and release index.
// Master stream: one beat is one result. tuser is the status; tdata carries
// the slot class, slot index and slot capacity in bytes (0 if too big or bad).
// Every request gives exactly one result, in request order.
// A release, a rejected allocate or a bad handle reaches the output through
// the queue and the output register; a successful allocate also waits for
// the free index from the ring memory's registered read port.
// Throughput: one request per cycle for releases and rejects while results
// are taken; a successful allocate holds the back end in its read state.
// A two-beat queue sits between the classifier and the ring engine, so
// requests keep flowing in while a result waits on a stalled receiver;
// s_axis_tready_o drops only when that queue is full.
// Reset: every ring reads as full, holding indices ascending from zero.
// No clearing pass is needed; a per-class write mark tells written ring
// words from untouched ones, so the block takes requests right after reset.
module size_class_pool_allocator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,  // [15:0] size, [18:16] release_class,
                                            // [29:19] release_index, [31:30] zero
  input  wire logic        s_axis_tuser_i,  // [0] op
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,  // [2:0] slot_class, [13:3] slot_index,
                                            // [28:14] slot_bytes, [31:29] zero
  output logic [2:0]       m_axis_tuser_o   // [2:0] status
);
  import scpa_pkg::*;

  logic               q_valid, q_ready;
  req_t               q_req;
  status_e            out_status;
  logic [CLS_W-1:0]   out_cls;
  logic [IDX_W-1:0]   out_idx;
  logic [BYTES_W-1:0] out_bytes;

  // Front: classify size into a class, check release handles, queue
  scpa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .op_i       (op_e'(s_axis_tuser_i)),
    .size_i     (s_axis_tdata_i[15:0]),
    .rcls_i     (s_axis_tdata_i[18:16]),
    .ridx_i     (s_axis_tdata_i[29:19]),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_req_o    (q_req)
  );

  // Back: ring pop/push against the free-index memory, output register
  scpa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_ready_o    (q_ready),
    .q_req_i      (q_req),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (out_status),
    .out_cls_o    (out_cls),
    .out_idx_o    (out_idx),
    .out_bytes_o  (out_bytes)
  );

  assign m_axis_tdata_o = {3'b000, out_bytes, out_idx, out_cls};
  assign m_axis_tuser_o = out_status;

  // A full queue always has something to offer the back end
  a_full_queue_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> q_valid)
    else $error("input stalled with an empty queue");

  // Too-big and bad-handle results carry no slot
  a_error_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_TOOBIG || m_axis_tuser_o == ST_BAD)
    |-> m_axis_tdata_o == '0)
    else $error("error result with non-zero slot fields");

  // Granted or released slots name a real class with its capacity
  a_slot_sane : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_ALLOC || m_axis_tuser_o == ST_FREED)
    |-> (32'(out_cls) < NUM_CLASSES) && (out_bytes == class_bytes(out_cls)))
    else $error("slot result with bad class or capacity");

endmodule

`default_nettype wire

>>> hw/rtl/scpa_ram.sv
`default_nettype none

module scpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/scpa_front.sv
`default_nettype none

module scpa_front (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire scpa_pkg::op_e           op_i,
  input  wire logic [scpa_pkg::SIZE_W-1:0] size_i,
  input  wire logic [scpa_pkg::CLS_W-1:0]  rcls_i,
  input  wire logic [scpa_pkg::IDX_W-1:0]  ridx_i,
  output logic                         q_valid_o,
  input  wire logic                    q_ready_i,
  output scpa_pkg::req_t               q_req_o
);
  import scpa_pkg::*;

  req_t              req;
  logic [CLS_W-1:0]  fit_cls;
  logic              fit;
  req_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  // Smallest class that fits: scan from the top so the lowest match wins
  always_comb begin
    fit_cls = '0;
    fit     = 1'b0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (size_i <= SIZE_W'(class_bytes(CLS_W'(c)))) begin
        fit_cls = CLS_W'(c);
        fit     = 1'b1;
      end
    end
  end

  always_comb begin
    req.op      = op_i;
    req.too_big = (op_i == OP_ALLOC) && !fit;
    req.bad     = (op_i == OP_RELEASE) &&
                  ((32'(rcls_i) >= NUM_CLASSES) ||
                   ({1'b0, ridx_i} >= class_cap(rcls_i)));
    req.cls     = (op_i == OP_ALLOC) ? fit_cls : rcls_i;
    req.idx     = ridx_i;
  end

  assign in_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign q_valid_o  = (cnt_q != '0);
  assign q_req_o    = mem_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= req;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/scpa_back.sv
`default_nettype none

module scpa_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        q_valid_i,
  output logic                             q_ready_o,
  input  wire scpa_pkg::req_t              q_req_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output scpa_pkg::status_e                out_status_o,
  output logic [scpa_pkg::CLS_W-1:0]       out_cls_o,
  output logic [scpa_pkg::IDX_W-1:0]       out_idx_o,
  output logic [scpa_pkg::BYTES_W-1:0]     out_bytes_o
);
  import scpa_pkg::*;

  back_state_e      state_q, state_d;

  // Per-class ring state; wmark counts ring positions written since reset
  logic [IDX_W-1:0] head_q  [NUM_CLASSES];
  logic [CNT_W-1:0] count_q [NUM_CLASSES];
  logic [CNT_W-1:0] wmark_q [NUM_CLASSES];
  logic [IDX_W-1:0] head_d  [NUM_CLASSES];
  logic [CNT_W-1:0] count_d [NUM_CLASSES];
  logic [CNT_W-1:0] wmark_d [NUM_CLASSES];

  // Pending read
  logic [CLS_W-1:0] rd_cls_q, rd_cls_d;
  logic [IDX_W-1:0] rd_pos_q, rd_pos_d;
  logic             rd_ram_q, rd_ram_d;

  // Output register
  logic             out_valid_q, out_valid_d;
  status_e          out_status_q, out_status_d;
  logic [CLS_W-1:0] out_cls_q, out_cls_d;
  logic [IDX_W-1:0] out_idx_q, out_idx_d;
  logic [BYTES_W-1:0] out_bytes_q, out_bytes_d;

  logic             out_free;
  logic [CLS_W-1:0] cls;
  logic [CNT_W-1:0] cap, cnt, head_ext, tail_sum, tail, head_nxt;
  logic             take_read;

  logic               ram_we, ram_re;
  logic [RING_AW-1:0] ram_waddr, ram_raddr;
  logic [IDX_W-1:0]   ram_wdata, ram_rdata;

  assign out_free = !out_valid_q || out_ready_i;

  // Guard the state lookup against an out-of-range release class
  always_comb begin
    cls      = q_req_i.bad ? '0 : q_req_i.cls;
    cap      = class_cap(cls);
    cnt      = count_q[cls];
    head_ext = {1'b0, head_q[cls]};
    tail_sum = head_ext + cnt;
    tail     = (tail_sum >= cap) ? tail_sum - cap : tail_sum;
    head_nxt = (head_ext + 1'b1 == cap) ? '0 : head_ext + 1'b1;
  end

  assign take_read = q_valid_i && out_free && (q_req_i.op == OP_ALLOC) &&
                     !q_req_i.too_big && (cnt != '0);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (take_read) begin
          state_d = BK_READ;
        end
      end
      BK_READ: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    q_ready_o    = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = class_base(cls) + RING_AW'(tail);
    ram_raddr    = class_base(cls) + RING_AW'(head_ext);
    ram_wdata    = q_req_i.idx;
    head_d       = head_q;
    count_d      = count_q;
    wmark_d      = wmark_q;
    rd_cls_d     = rd_cls_q;
    rd_pos_d     = rd_pos_q;
    rd_ram_d     = rd_ram_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_cls_d    = out_cls_q;
    out_idx_d    = out_idx_q;
    out_bytes_d  = out_bytes_q;

    case (state_q)
      BK_IDLE: begin
        if (q_valid_i && out_free) begin
          q_ready_o    = 1'b1;
          out_valid_d  = 1'b1;
          out_status_d = ST_BAD;
          out_cls_d    = '0;
          out_idx_d    = '0;
          out_bytes_d  = '0;
          if (q_req_i.op == OP_RELEASE) begin
            if (!q_req_i.bad && (cnt < cap)) begin
              ram_we       = 1'b1;
              count_d[cls] = cnt + 1'b1;
              if (wmark_q[cls] < cap) begin
                wmark_d[cls] = wmark_q[cls] + 1'b1;
              end
              out_status_d = ST_FREED;
              out_cls_d    = cls;
              out_idx_d    = q_req_i.idx;
              out_bytes_d  = class_bytes(cls);
            end
          end else if (q_req_i.too_big) begin
            out_status_d = ST_TOOBIG;
          end else if (cnt == '0) begin
            out_status_d = ST_EMPTY;
            out_cls_d    = cls;
          end else begin
            // Successful pop: result follows once the ring word is read
            ram_re       = 1'b1;
            out_valid_d  = 1'b0;
            head_d[cls]  = IDX_W'(head_nxt);
            count_d[cls] = cnt - 1'b1;
            rd_cls_d     = cls;
            rd_pos_d     = IDX_W'(head_ext);
            rd_ram_d     = head_ext < wmark_q[cls];
          end
        end
      end
      BK_READ: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_ALLOC;
          out_cls_d    = rd_cls_q;
          // Never-written positions still hold their reset index
          out_idx_d    = rd_ram_q ? ram_rdata : rd_pos_q;
          out_bytes_d  = class_bytes(rd_cls_q);
        end
      end
      default: begin
      end
    endcase
  end

  scpa_ram #(
    .WIDTH(IDX_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_q[c]  <= '0;
        count_q[c] <= class_cap(CLS_W'(c));
        wmark_q[c] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      count_q     <= count_d;
      wmark_q     <= wmark_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_cls_q     <= rd_cls_d;
    rd_pos_q     <= rd_pos_d;
    rd_ram_q     <= rd_ram_d;
    out_status_q <= out_status_d;
    out_cls_q    <= out_cls_d;
    out_idx_q    <= out_idx_d;
    out_bytes_q  <= out_bytes_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_cls_o    = out_cls_q;
  assign out_idx_o    = out_idx_q;
  assign out_bytes_o  = out_bytes_q;

endmodule

`default_nettype wire
